/* src/pfsr_pkg.sv */
// ----------------------------------------------------------------------------
// pfsr_pkg
// Shared types, constants and field helpers for the prime-field sponge round.
// ----------------------------------------------------------------------------
package pfsr_pkg;

  localparam int unsigned FieldBits = 64;
  localparam int unsigned CntBits   = $clog2(FieldBits);

  typedef logic [FieldBits-1:0] fword_t;

  // register indexes on the configuration port
  localparam logic [2:0] RegPrime = 3'd0;
  localparam logic [2:0] RegFwd   = 3'd1;
  localparam logic [2:0] RegInv   = 3'd2;
  localparam logic [2:0] RegDelta = 3'd3;
  localparam logic [2:0] RegMu    = 3'd4;

  localparam logic [63:0] PrimeRst = 64'hFFFF_FFFF_0000_0001;
  localparam logic [7:0]  FwdRst   = 8'd7;
  localparam logic [63:0] InvRst   = 64'd10540996611094048183;
  localparam logic [63:0] DeltaRst = 64'd386135515175;
  localparam logic [63:0] MuRst    = 64'd384403472705;

  // operand slots: state words, round constants, delta, mu
  localparam logic [2:0] SlotW2    = 3'd2;
  localparam logic [2:0] SlotC0    = 3'd3;
  localparam logic [2:0] SlotDelta = 3'd6;
  localparam logic [2:0] SlotMu    = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED,
    S_POW_SQ,
    S_POW_MUL,
    S_POW_NEXT,
    S_Q_SQ,
    S_Q_DL,
    S_Q_W2,
    S_MIX,
    S_FIN
  } state_e;

  typedef struct packed {
    logic   start;
    fword_t a;
    fword_t b;
  } mm_req_t;

  typedef struct packed {
    logic   done;
    fword_t res;
  } mm_rsp_t;

  // a + b mod p, both operands below p
  function automatic fword_t add_mod(fword_t a, fword_t b, fword_t p);
    logic [FieldBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, p}) begin
      s = s - {1'b0, p};
    end
    return s[FieldBits-1:0];
  endfunction

endpackage

/* src/pfsr_mulmod.sv */
// ----------------------------------------------------------------------------
// pfsr_mulmod
// Bit-serial modular multiplier: one double-and-add step per cycle, MSB first.
// ----------------------------------------------------------------------------
module pfsr_mulmod (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfsr_pkg::fword_t  p_i,
  input  pfsr_pkg::mm_req_t req_i,
  output pfsr_pkg::mm_rsp_t rsp_o
);

  pfsr_pkg::fword_t r_q, r_d, a_q, b_q;
  logic [pfsr_pkg::CntBits-1:0] cnt_q;
  logic active_q, done_q;
  pfsr_pkg::fword_t dbl;

  always_comb begin
    dbl = pfsr_pkg::add_mod(r_q, r_q, p_i);
    r_d = b_q[pfsr_pkg::FieldBits-1] ? pfsr_pkg::add_mod(dbl, a_q, p_i) : dbl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (active_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (&cnt_q) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      r_q <= '0;
      a_q <= req_i.a;
      b_q <= req_i.b;
    end else if (active_q) begin
      r_q <= r_d;
      b_q <= {b_q[pfsr_pkg::FieldBits-2:0], 1'b0};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = r_q;

endmodule

/* src/prime_field_sponge_round.sv */
// ----------------------------------------------------------------------------
// prime_field_sponge_round
// One round of a width-3 prime-field permutation on a shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start_i with the six operand words while busy_o is low; the
//   transaction is taken on that edge and busy_o stays high until the result
//   has been shown. valid_o is high for exactly one cycle with out_zero_o,
//   out_one_o and out_two_o; the receiver takes it then and cannot stall.
//   Write the registers through cfg_we_i/cfg_idx_i/cfg_data_i only while
//   busy_o is low; the block does not enforce this. Unknown indexes are ignored.
// Timing:
//   All work runs on one bit-serial modular multiplier. An item needs 8
//   reductions, two square-and-multiply power maps over 64 exponent bits
//   (64 squarings plus one product per set bit each), 3 products for the
//   quadratic factor and 12 add steps for the mix. A new transaction can be
//   taken in the cycle after the result.
//   With a modulus below two the all-zero result is shown in the cycle
//   right after acceptance.
// Reset:
//   rst_ni returns the block to idle and the registers to their defaults.
// ----------------------------------------------------------------------------
module prime_field_sponge_round (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [63:0] word_zero_i,
  input  logic [63:0] word_one_i,
  input  logic [63:0] word_two_i,
  input  logic [63:0] round_const_zero_i,
  input  logic [63:0] round_const_one_i,
  input  logic [63:0] round_const_two_i,
  output logic        valid_o,
  output logic [63:0] out_zero_o,
  output logic [63:0] out_one_o,
  output logic [63:0] out_two_o
);

  pfsr_pkg::fword_t prime_q, inv_q, delta_q, mu_q;
  logic [7:0]       fwd_q;

  pfsr_pkg::state_e state_q, state_d;
  pfsr_pkg::fword_t opnd_q [8];
  pfsr_pkg::fword_t s0_q, s1_q, s2_q, r_q, t_q, u_q, acc_q;
  pfsr_pkg::fword_t out0_q, out1_q, out2_q;
  logic [2:0]       idx_q;
  logic [pfsr_pkg::CntBits-1:0] bit_q;
  logic             sel_q, pend_q;
  logic [1:0]       oi_q, oj_q;

  pfsr_pkg::mm_req_t mreq;
  pfsr_pkg::mm_rsp_t mrsp;
  pfsr_pkg::fword_t  lsum, expo, base, mix_op, mix_sum;
  logic              accept, op_state;

  assign accept = start_i && !busy_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_q <= pfsr_pkg::PrimeRst;
      fwd_q   <= pfsr_pkg::FwdRst;
      inv_q   <= pfsr_pkg::InvRst;
      delta_q <= pfsr_pkg::DeltaRst;
      mu_q    <= pfsr_pkg::MuRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pfsr_pkg::RegPrime: prime_q <= cfg_data_i;
        pfsr_pkg::RegFwd:   fwd_q   <= cfg_data_i[7:0];
        pfsr_pkg::RegInv:   inv_q   <= cfg_data_i;
        pfsr_pkg::RegDelta: delta_q <= cfg_data_i;
        pfsr_pkg::RegMu:    mu_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pfsr_mulmod u_mulmod (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .p_i   (prime_q),
    .req_i (mreq),
    .rsp_o (mrsp)
  );

  assign lsum = pfsr_pkg::add_mod(s0_q, s1_q, prime_q);
  assign expo = sel_q ? {56'd0, fwd_q} : inv_q;
  assign base = sel_q ? opnd_q[1] : opnd_q[0];

  // mix: out_i = 2*s_i + s_(i+1) + s_(i+2) + c_i
  always_comb begin
    mix_op = s0_q;
    unique case ({oi_q, oj_q})
      4'b00_00: mix_op = s0_q;
      4'b00_01: mix_op = s1_q;
      4'b00_10: mix_op = s2_q;
      4'b01_00: mix_op = s1_q;
      4'b01_01: mix_op = s2_q;
      4'b01_10: mix_op = s0_q;
      4'b10_00: mix_op = s2_q;
      4'b10_01: mix_op = s0_q;
      4'b10_10: mix_op = s1_q;
      default:  mix_op = opnd_q[pfsr_pkg::SlotC0 + {1'b0, oi_q}];
    endcase
    mix_sum = pfsr_pkg::add_mod((oj_q == 2'd0) ? mix_op : acc_q,
                                (oj_q == 2'd0) ? mix_op : mix_op, prime_q);
    if (oj_q != 2'd0) begin
      mix_sum = pfsr_pkg::add_mod(acc_q, mix_op, prime_q);
    end
  end

  assign op_state = (state_q == pfsr_pkg::S_RED)    || (state_q == pfsr_pkg::S_POW_SQ) ||
                    (state_q == pfsr_pkg::S_POW_MUL) || (state_q == pfsr_pkg::S_Q_SQ)  ||
                    (state_q == pfsr_pkg::S_Q_DL)   || (state_q == pfsr_pkg::S_Q_W2);

  always_comb begin
    mreq.start = op_state && !pend_q;
    mreq.a     = r_q;
    mreq.b     = r_q;
    unique case (state_q)
      pfsr_pkg::S_RED: begin
        mreq.a = pfsr_pkg::fword_t'(1);
        mreq.b = opnd_q[idx_q];
      end
      pfsr_pkg::S_POW_MUL: mreq.b = base;
      pfsr_pkg::S_Q_SQ: begin
        mreq.a = lsum;
        mreq.b = lsum;
      end
      pfsr_pkg::S_Q_DL: begin
        mreq.a = opnd_q[pfsr_pkg::SlotDelta];
        mreq.b = lsum;
      end
      pfsr_pkg::S_Q_W2: begin
        mreq.a = pfsr_pkg::add_mod(t_q, u_q, prime_q);
        mreq.b = opnd_q[pfsr_pkg::SlotW2];
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pfsr_pkg::S_IDLE:
        if (accept) begin
          state_d = (prime_q < 64'd2) ? pfsr_pkg::S_FIN : pfsr_pkg::S_RED;
        end
      pfsr_pkg::S_RED:
        if (mrsp.done && idx_q == 3'd7) state_d = pfsr_pkg::S_POW_SQ;
      pfsr_pkg::S_POW_SQ:
        if (mrsp.done) begin
          state_d = expo[bit_q] ? pfsr_pkg::S_POW_MUL : pfsr_pkg::S_POW_NEXT;
        end
      pfsr_pkg::S_POW_MUL:
        if (mrsp.done) state_d = pfsr_pkg::S_POW_NEXT;
      pfsr_pkg::S_POW_NEXT:
        if (bit_q == '0 && sel_q) state_d = pfsr_pkg::S_Q_SQ;
        else                      state_d = pfsr_pkg::S_POW_SQ;
      pfsr_pkg::S_Q_SQ:
        if (mrsp.done) state_d = pfsr_pkg::S_Q_DL;
      pfsr_pkg::S_Q_DL:
        if (mrsp.done) state_d = pfsr_pkg::S_Q_W2;
      pfsr_pkg::S_Q_W2:
        if (mrsp.done) state_d = pfsr_pkg::S_MIX;
      pfsr_pkg::S_MIX:
        if (oi_q == 2'd2 && oj_q == 2'd3) state_d = pfsr_pkg::S_FIN;
      pfsr_pkg::S_FIN:
        state_d = pfsr_pkg::S_IDLE;
      default: state_d = pfsr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfsr_pkg::S_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mreq.start)     pend_q <= 1'b1;
      else if (mrsp.done) pend_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      pfsr_pkg::S_IDLE:
        if (accept) begin
          opnd_q[0] <= word_zero_i;
          opnd_q[1] <= word_one_i;
          opnd_q[2] <= word_two_i;
          opnd_q[3] <= round_const_zero_i;
          opnd_q[4] <= round_const_one_i;
          opnd_q[5] <= round_const_two_i;
          opnd_q[6] <= delta_q;
          opnd_q[7] <= mu_q;
          idx_q     <= '0;
          out0_q    <= '0;
          out1_q    <= '0;
          out2_q    <= '0;
        end
      pfsr_pkg::S_RED:
        if (mrsp.done) begin
          opnd_q[idx_q] <= mrsp.res;
          idx_q         <= idx_q + 1'b1;
          r_q           <= pfsr_pkg::fword_t'(1);
          bit_q         <= '1;
          sel_q         <= 1'b0;
        end
      pfsr_pkg::S_POW_SQ, pfsr_pkg::S_POW_MUL:
        if (mrsp.done) r_q <= mrsp.res;
      pfsr_pkg::S_POW_NEXT:
        if (bit_q == '0) begin
          if (sel_q) s1_q <= r_q;
          else       s0_q <= r_q;
          sel_q <= 1'b1;
          r_q   <= pfsr_pkg::fword_t'(1);
          bit_q <= '1;
        end else begin
          bit_q <= bit_q - 1'b1;
        end
      pfsr_pkg::S_Q_SQ:
        if (mrsp.done) t_q <= mrsp.res;
      pfsr_pkg::S_Q_DL:
        if (mrsp.done) u_q <= pfsr_pkg::add_mod(mrsp.res, opnd_q[pfsr_pkg::SlotMu], prime_q);
      pfsr_pkg::S_Q_W2:
        if (mrsp.done) begin
          s2_q <= mrsp.res;
          oi_q <= '0;
          oj_q <= '0;
        end
      pfsr_pkg::S_MIX: begin
        acc_q <= mix_sum;
        if (oj_q == 2'd3) begin
          unique case (oi_q)
            2'd0:    out0_q <= mix_sum;
            2'd1:    out1_q <= mix_sum;
            default: out2_q <= mix_sum;
          endcase
          oi_q <= oi_q + 1'b1;
          oj_q <= '0;
        end else begin
          oj_q <= oj_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign busy_o     = (state_q != pfsr_pkg::S_IDLE);
  assign valid_o    = (state_q == pfsr_pkg::S_FIN);
  assign out_zero_o = out0_q;
  assign out_one_o  = out1_q;
  assign out_two_o  = out2_q;

endmodule

/* src/pfsr_checker.sv */
// ----------------------------------------------------------------------------
// pfsr_checker
// Port-level checks on the start/busy/valid sequencing of the round block.
// ----------------------------------------------------------------------------
module pfsr_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic valid_o
);

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy not raised after accepted transaction");

  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_o)
    else $error("result shown while idle");

  a_valid_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> (!valid_o && !busy_o))
    else $error("result not a single-cycle pulse ending the transaction");

  a_fall_after_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> $past(valid_o))
    else $error("busy dropped without a result");

endmodule

bind prime_field_sponge_round pfsr_checker u_pfsr_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start_i(start_i),
  .busy_o (busy_o),
  .valid_o(valid_o)
);

/* tb/tb_prime_field_sponge_round.sv */
// ----------------------------------------------------------------------------
// tb_prime_field_sponge_round
// Self-checking bench for one width-3 prime-field permutation round.
// ----------------------------------------------------------------------------
// A queue of round operands is filled phase by phase under a range of field
// settings. The driver issues them with random gaps, a bit-exact round
// calculator predicts each output triple at acceptance, and the monitor
// compares every valid_o transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_prime_field_sponge_round;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    pfsr_pkg::fword_t w0, w1, w2, c0, c1, c2;
    bit               drain_first;
  } round_in_t;

  typedef struct {
    pfsr_pkg::fword_t o0, o1, o2;
  } round_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = pfsr_pkg::RegPrime;
  logic [63:0] cfg_data_i = '0;
  logic        start_i = 1'b0;
  logic        busy_o, valid_o;
  logic [63:0] word_zero_i = '0, word_one_i = '0, word_two_i = '0;
  logic [63:0] round_const_zero_i = '0, round_const_one_i = '0, round_const_two_i = '0;
  logic [63:0] out_zero_o, out_one_o, out_two_o;

  // field settings as the block should hold them
  pfsr_pkg::fword_t fld_p, fld_inv, fld_delta, fld_mu;
  logic [7:0]       fld_alpha;

  round_in_t  operand_q[$];
  round_out_t round_q[$];
  round_in_t  cur_op;
  bit         took;
  int         gap, errors, idle_cycles;

  prime_field_sponge_round i_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic pfsr_pkg::fword_t fadd(pfsr_pkg::fword_t a, pfsr_pkg::fword_t b,
                                            pfsr_pkg::fword_t p);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, p}) s = s - {1'b0, p};
    return s[63:0];
  endfunction

  function automatic pfsr_pkg::fword_t fmul(pfsr_pkg::fword_t a, pfsr_pkg::fword_t b,
                                            pfsr_pkg::fword_t p);
    logic [127:0] t;
    t = {64'd0, a} * {64'd0, b};
    t = t % {64'd0, p};
    return t[63:0];
  endfunction

  function automatic pfsr_pkg::fword_t fpow(pfsr_pkg::fword_t x, pfsr_pkg::fword_t e,
                                            pfsr_pkg::fword_t p);
    pfsr_pkg::fword_t r;
    r = 64'd1 % p;
    for (int k = 63; k >= 0; k--) begin
      r = fmul(r, r, p);
      if (e[k]) r = fmul(r, x, p);
    end
    return r;
  endfunction

  function automatic round_out_t calc_round(round_in_t op);
    round_out_t       r;
    pfsr_pkg::fword_t p, s0, s1, s2, l, quad, dl, mu, two;
    p = fld_p;
    if (p < 2) begin
      r.o0 = '0;
      r.o1 = '0;
      r.o2 = '0;
      return r;
    end
    dl   = fld_delta % p;
    mu   = fld_mu % p;
    s0   = fpow(op.w0 % p, fld_inv, p);
    s1   = fpow(op.w1 % p, {56'd0, fld_alpha}, p);
    l    = fadd(s0, s1, p);
    quad = fadd(fmul(l, l, p), fadd(fmul(dl, l, p), mu, p), p);
    s2   = fmul(op.w2 % p, quad, p);
    // circulant (2,1,1): own word doubled plus the other two
    two  = 64'd2 % p;
    r.o0 = fadd(fadd(fadd(fmul(two, s0, p), s1, p), s2, p), op.c0 % p, p);
    r.o1 = fadd(fadd(fadd(s0, fmul(two, s1, p), p), s2, p), op.c1 % p, p);
    r.o2 = fadd(fadd(fadd(s0, s1, p), fmul(two, s2, p), p), op.c2 % p, p);
    return r;
  endfunction

  function automatic pfsr_pkg::fword_t rnd64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic pfsr_pkg::fword_t pick_word(pfsr_pkg::fword_t p);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return p - 1;
      2:       return '1;
      3:       return p + rnd64() % 64'd16;
      4, 5:    return rnd64();
      default: return (p > 1) ? rnd64() % p : rnd64();
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  // driver: operands change on the falling edge
  always @(negedge clk_i) begin
    if (start_i && !took) begin
      // still waiting for the block to take it
    end else if (gap > 0) begin
      gap     <= gap - 1;
      start_i <= 1'b0;
    end else if (operand_q.size() > 0 &&
                 (!operand_q[0].drain_first ||
                  (round_q.size() == 0 && !busy_o && !start_i))) begin
      cur_op             <= operand_q[0];
      word_zero_i        <= operand_q[0].w0;
      word_one_i         <= operand_q[0].w1;
      word_two_i         <= operand_q[0].w2;
      round_const_zero_i <= operand_q[0].c0;
      round_const_one_i  <= operand_q[0].c1;
      round_const_two_i  <= operand_q[0].c2;
      void'(operand_q.pop_front());
      start_i <= 1'b1;
      gap     <= pick_gap();
    end else begin
      start_i <= 1'b0;
    end
  end

  // acceptance, monitor and watchdog
  always @(posedge clk_i) begin
    round_out_t exp_r;
    took <= start_i && !busy_o;
    if (start_i && !busy_o) round_q.push_back(calc_round(cur_op));
    if (valid_o) begin
      if (round_q.size() == 0) begin
        $display("%0t: result with none outstanding: %h %h %h", $time,
                 out_zero_o, out_one_o, out_two_o);
        errors++;
      end else begin
        exp_r = round_q.pop_front();
        if (out_zero_o !== exp_r.o0) begin
          $display("%0t: out_zero exp %h got %h", $time, exp_r.o0, out_zero_o);
          errors++;
        end
        if (out_one_o !== exp_r.o1) begin
          $display("%0t: out_one exp %h got %h", $time, exp_r.o1, out_one_o);
          errors++;
        end
        if (out_two_o !== exp_r.o2) begin
          $display("%0t: out_two exp %h got %h", $time, exp_r.o2, out_two_o);
          errors++;
        end
      end
    end
    if (valid_o || (start_i && !busy_o)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > 100000) begin
      $display("prime_field_sponge_round: mismatch");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      pfsr_pkg::RegPrime: fld_p = data;
      pfsr_pkg::RegFwd:   fld_alpha = data[7:0];
      pfsr_pkg::RegInv:   fld_inv = data;
      pfsr_pkg::RegDelta: fld_delta = data;
      pfsr_pkg::RegMu:    fld_mu = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    wait (operand_q.size() == 0 && round_q.size() == 0 && !start_i);
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    repeat (5) @(negedge clk_i);
  endtask

  task automatic queue_op(pfsr_pkg::fword_t w0, w1, w2, c0, c1, c2, bit drain = 0);
    round_in_t op;
    op = '{w0, w1, w2, c0, c1, c2, drain};
    operand_q.push_back(op);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) begin
      queue_op(pick_word(fld_p), pick_word(fld_p), pick_word(fld_p),
               pick_word(fld_p), pick_word(fld_p), pick_word(fld_p),
               $urandom_range(0, 40) == 0);
    end
  endtask

  initial begin
    fld_p     = pfsr_pkg::PrimeRst;
    fld_alpha = pfsr_pkg::FwdRst;
    fld_inv   = pfsr_pkg::InvRst;
    fld_delta = pfsr_pkg::DeltaRst;
    fld_mu    = pfsr_pkg::MuRst;
    gap = 0;
    errors = 0;
    idle_cycles = 0;
    took = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // defaults: directed corners, then random
    queue_op('0, '0, '0, '0, '0, '0);
    queue_op('1, '1, '1, '1, '1, '1);
    queue_op(fld_p - 1, fld_p - 1, fld_p - 1, fld_p - 1, fld_p - 1, fld_p - 1);
    queue_op(fld_p, fld_p, fld_p, fld_p, fld_p, fld_p);
    queue_op(64'd1, 64'd1, 64'd1, 64'd0, 64'd0, 64'd0);
    queue_op(64'd0, 64'd5, 64'd7, 64'd1, 64'd2, 64'd3, 1'b1);
    queue_op(64'd9, 64'd0, '1, fld_p - 1, 64'd0, '1);
    queue_random(150);
    wait_idle();

    // composite all-ones modulus, largest alpha, wrong inverse, extreme coefs
    write_reg(pfsr_pkg::RegPrime, '1);
    write_reg(pfsr_pkg::RegFwd, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(pfsr_pkg::RegInv, rnd64());
    write_reg(pfsr_pkg::RegDelta, '1);
    write_reg(pfsr_pkg::RegMu, '0);
    write_reg(3'd5, rnd64());
    write_reg(3'd7, rnd64());
    queue_op('0, '0, '0, '0, '0, '0);
    queue_op('1, '1, '1, '1, '1, '1);
    queue_random(100);
    wait_idle();

    // smallest odd prime, inverse exponent of one
    write_reg(pfsr_pkg::RegPrime, 64'd3);
    write_reg(pfsr_pkg::RegFwd, 64'd3);
    write_reg(pfsr_pkg::RegInv, 64'd1);
    write_reg(pfsr_pkg::RegDelta, 64'd5);
    write_reg(pfsr_pkg::RegMu, '1);
    queue_op('0, '0, '0, '0, '0, '0);
    queue_op('1, '1, '1, '1, '1, '1);
    queue_random(80);
    wait_idle();

    // degenerate moduli: all results zero for 0 and 1, plain mod 2 arithmetic
    write_reg(pfsr_pkg::RegPrime, 64'd0);
    queue_random(40);
    wait_idle();
    write_reg(pfsr_pkg::RegPrime, 64'd1);
    write_reg(3'd6, rnd64());
    queue_random(20);
    wait_idle();
    write_reg(pfsr_pkg::RegPrime, 64'd2);
    write_reg(pfsr_pkg::RegInv, '1);
    queue_random(40);
    wait_idle();

    // random odd modulus and exponents
    write_reg(pfsr_pkg::RegPrime, rnd64() | 64'h8000_0000_0000_0001);
    write_reg(pfsr_pkg::RegFwd, 64'($urandom_range(3, 255)));
    write_reg(pfsr_pkg::RegInv, rnd64());
    write_reg(pfsr_pkg::RegDelta, rnd64());
    write_reg(pfsr_pkg::RegMu, rnd64());
    queue_random(100);
    wait_idle();

    repeat (50) @(negedge clk_i);
    if (errors == 0 && round_q.size() == 0) begin
      $display("prime_field_sponge_round: match");
    end else begin
      $display("prime_field_sponge_round: mismatch");
    end
    $finish;
  end

endmodule
